// ===== rtl/rlwq_pkg.sv =====
// Shared constants, types and state codes of the recursive lock unit.
package rlwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int COUNT_BITS  = 8;

  localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_SPACE  = 1 << ID_BITS;

  localparam int REQ_WIDTH    = 8;
  localparam int STATUS_WIDTH = 4;
  localparam int WOKE_WIDTH   = 8;
  localparam int HOLD_WIDTH   = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [FILL_BITS-1:0]  FILL_FULL = FILL_BITS'(QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [ID_BITS-1:0]    ID_LAST   = ID_BITS'(ID_SPACE - 1);

  typedef enum logic {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_GRANTED    = 4'd0,
    ST_NESTED     = 4'd1,
    ST_QUEUED     = 4'd2,
    ST_UNNESTED   = 4'd3,
    ST_FREED      = 4'd4,
    ST_HANDED     = 4'd5,
    ST_NOT_HOLDER = 4'd6,
    ST_QUEUE_FULL = 4'd7,
    ST_DUP_WAITER = 4'd8,
    ST_OVERFLOW   = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // Lock state and memory read data seen by the decision logic.
  typedef struct packed {
    logic                  taken;
    logic [ID_BITS-1:0]    owner_id;
    logic [COUNT_BITS-1:0] nest_count;
    logic [FILL_BITS-1:0]  fifo_fill;
    logic                  waiting;
    logic [ID_BITS-1:0]    head_id;
  } lock_view_t;

  // Decision for one request: result fields and state updates.
  typedef struct packed {
    status_t               status;
    logic                  woke_valid;
    logic [ID_BITS-1:0]    woke_id;
    logic                  taken_next;
    logic [ID_BITS-1:0]    owner_next;
    logic [COUNT_BITS-1:0] count_next;
    logic                  enqueue;
    logic                  dequeue;
  } lock_update_t;

endpackage

// ===== rtl/rlwq_decide.sv =====
// Decision logic for one acquire or release request.
module rlwq_decide (
  input  rlwq_pkg::func_t              func,
  input  logic [rlwq_pkg::ID_BITS-1:0] req_id,
  input  rlwq_pkg::lock_view_t         view,
  output rlwq_pkg::lock_update_t       upd
);

  always_comb begin
    upd            = '0;
    upd.status     = rlwq_pkg::ST_NOT_HOLDER;
    upd.taken_next = view.taken;
    upd.owner_next = view.owner_id;
    upd.count_next = view.nest_count;
    if (func == rlwq_pkg::FUNC_ACQUIRE) begin
      if (!view.taken) begin
        upd.taken_next = 1'b1;
        upd.owner_next = req_id;
        upd.count_next = rlwq_pkg::COUNT_ONE;
        upd.status     = rlwq_pkg::ST_GRANTED;
      end else if (view.owner_id == req_id) begin
        if (view.nest_count == rlwq_pkg::COUNT_MAX) begin
          upd.status = rlwq_pkg::ST_OVERFLOW;
        end else begin
          upd.count_next = view.nest_count + rlwq_pkg::COUNT_ONE;
          upd.status     = rlwq_pkg::ST_NESTED;
        end
      end else if (view.waiting) begin
        upd.status = rlwq_pkg::ST_DUP_WAITER;
      end else if (view.fifo_fill == rlwq_pkg::FILL_FULL) begin
        upd.status = rlwq_pkg::ST_QUEUE_FULL;
      end else begin
        upd.enqueue = 1'b1;
        upd.status  = rlwq_pkg::ST_QUEUED;
      end
    end else begin
      if (!view.taken || view.owner_id != req_id) begin
        upd.status = rlwq_pkg::ST_NOT_HOLDER;
      end else if (view.nest_count > rlwq_pkg::COUNT_ONE) begin
        upd.count_next = view.nest_count - rlwq_pkg::COUNT_ONE;
        upd.status     = rlwq_pkg::ST_UNNESTED;
      end else if (view.fifo_fill != '0) begin
        // hand the lock straight to the head waiter
        upd.dequeue    = 1'b1;
        upd.owner_next = view.head_id;
        upd.count_next = rlwq_pkg::COUNT_ONE;
        upd.woke_valid = 1'b1;
        upd.woke_id    = view.head_id;
        upd.status     = rlwq_pkg::ST_HANDED;
      end else begin
        upd.taken_next = 1'b0;
        upd.owner_next = '0;
        upd.count_next = '0;
        upd.status     = rlwq_pkg::ST_FREED;
      end
    end
  end

endmodule

// ===== rtl/recursive_lock_with_wait_queue_core.sv =====
// Top level of the recursive lock unit with a FIFO of blocked requesters.
// A request is captured together with both memory reads, decided in the EXEC state and
// its result registered in the output register. A new request is taken only once the last
//   is decided, as the waiter FIFO memory and the waiting-map memory are read then updated.
// Reset: synchronous; clears the lock registers, then sweeps the 256-entry waiting
//   map to zero, one entry a cycle, before the first request transfer.
module recursive_lock_with_wait_queue_core (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] requester
  input  logic        s_tuser,   // [0] func (0 acquire, 1 release)
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] woke_id, [15:8] hold_count
  output logic [4:0]  m_tuser    // [3:0] status, [4] woke_valid
);

  // Lock registers
  logic                            taken;
  logic [rlwq_pkg::ID_BITS-1:0]    owner_id;
  logic [rlwq_pkg::COUNT_BITS-1:0] nest_count;
  logic [rlwq_pkg::PTR_BITS-1:0]   fifo_head;
  logic [rlwq_pkg::PTR_BITS-1:0]   fifo_tail;
  logic [rlwq_pkg::FILL_BITS-1:0]  fifo_fill;

  // Sequencer
  rlwq_pkg::fsm_t               state;
  rlwq_pkg::fsm_t               state_next;
  logic [rlwq_pkg::ID_BITS-1:0] clr_addr;

  // Captured request
  rlwq_pkg::func_t              func_q;
  logic [rlwq_pkg::ID_BITS-1:0] req_q;

  // Memories and their registered read data
  logic [rlwq_pkg::ID_BITS-1:0] wait_fifo [rlwq_pkg::QUEUE_DEPTH];
  logic                         waiting_map [rlwq_pkg::ID_SPACE];
  logic [rlwq_pkg::ID_BITS-1:0] head_rd;
  logic                         map_rd;

  // Output register
  rlwq_pkg::status_t            status_q;
  logic                         woke_valid_q;
  logic [rlwq_pkg::ID_BITS-1:0] woke_id_q;
  logic [rlwq_pkg::COUNT_BITS-1:0] count_q;

  logic                         in_xfer;
  logic                         exec_en;
  logic                         clear_en;
  logic                         map_we;
  logic [rlwq_pkg::ID_BITS-1:0] map_wa;
  logic                         map_wd;
  logic [rlwq_pkg::ID_BITS-1:0] req_in;

  rlwq_pkg::lock_view_t   view;
  rlwq_pkg::lock_update_t upd;

  assign req_in  = s_tdata[rlwq_pkg::ID_BITS-1:0];
  assign in_xfer = s_tvalid && s_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rlwq_pkg::FSM_CLEAR: begin
        if (clr_addr == rlwq_pkg::ID_LAST) begin
          state_next = rlwq_pkg::FSM_IDLE;
        end
      end
      rlwq_pkg::FSM_IDLE: begin
        if (s_tvalid && (!m_tvalid || m_tready)) begin
          state_next = rlwq_pkg::FSM_EXEC;
        end
      end
      rlwq_pkg::FSM_EXEC: state_next = rlwq_pkg::FSM_IDLE;
      default:            state_next = rlwq_pkg::FSM_CLEAR;
    endcase
  end

  // Sequencer outputs. Take a request only when the output register is free
  // by the time the decision lands in it.
  always_comb begin
    s_tready = 1'b0;
    exec_en  = 1'b0;
    clear_en = 1'b0;
    case (state)
      rlwq_pkg::FSM_CLEAR: clear_en = 1'b1;
      rlwq_pkg::FSM_IDLE:  s_tready = !m_tvalid || m_tready;
      rlwq_pkg::FSM_EXEC:  exec_en  = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rlwq_pkg::FSM_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clear_en) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Capture the request and read both memories in the same cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_q  <= rlwq_pkg::func_t'(s_tuser);
      req_q   <= req_in;
      map_rd  <= waiting_map[req_in];
      head_rd <= wait_fifo[fifo_head];
    end
  end

  assign view.taken      = taken;
  assign view.owner_id   = owner_id;
  assign view.nest_count = nest_count;
  assign view.fifo_fill  = fifo_fill;
  assign view.waiting    = map_rd;
  assign view.head_id    = head_rd;

  rlwq_decide u_decide (
    .func   (func_q),
    .req_id (req_q),
    .view   (view),
    .upd    (upd)
  );

  // Waiting map write port: clear sweep, set on enqueue, drop on handoff.
  // Enqueue and dequeue never coincide, so one port serves both.
  always_comb begin
    map_we = 1'b0;
    map_wa = clr_addr;
    map_wd = 1'b0;
    if (clear_en) begin
      map_we = 1'b1;
    end else if (exec_en && upd.enqueue) begin
      map_we = 1'b1;
      map_wa = req_q;
      map_wd = 1'b1;
    end else if (exec_en && upd.dequeue) begin
      map_we = 1'b1;
      map_wa = head_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      waiting_map[map_wa] <= map_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en && upd.enqueue) begin
      wait_fifo[fifo_tail] <= req_q;
    end
  end

  // Lock register update
  always_ff @(posedge clk) begin
    if (rst) begin
      taken      <= 1'b0;
      owner_id   <= '0;
      nest_count <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_fill  <= '0;
    end else if (exec_en) begin
      taken      <= upd.taken_next;
      owner_id   <= upd.owner_next;
      nest_count <= upd.count_next;
      if (upd.enqueue) begin
        fifo_tail <= (fifo_tail == rlwq_pkg::PTR_LAST) ? '0 : fifo_tail + 1'b1;
        fifo_fill <= fifo_fill + 1'b1;
      end else if (upd.dequeue) begin
        fifo_head <= (fifo_head == rlwq_pkg::PTR_LAST) ? '0 : fifo_head + 1'b1;
        fifo_fill <= fifo_fill - 1'b1;
      end
    end
  end

  // Output register: load on decision, hold until the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      status_q     <= upd.status;
      woke_valid_q <= upd.woke_valid;
      woke_id_q    <= upd.woke_id;
      count_q      <= upd.count_next;
    end
  end

  assign m_tuser = {woke_valid_q, status_q};
  assign m_tdata = {rlwq_pkg::HOLD_WIDTH'(count_q), rlwq_pkg::WOKE_WIDTH'(woke_id_q)};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the recursive lock unit with its FIFO of waiters.
`timescale 1ns / 1ps

module tb_top;

  // One result as the checker sees it.
  typedef struct {
    rlwq_pkg::status_t                status;
    logic                             woke_valid;
    logic [rlwq_pkg::WOKE_WIDTH-1:0]  woke_id;
    logic [rlwq_pkg::HOLD_WIDTH-1:0]  hold_count;
  } lock_outcome_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [7:0] requester
  logic        s_tuser = rlwq_pkg::FUNC_ACQUIRE;  // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // [7:0] woke_id, [15:8] hold_count
  logic [4:0]  m_tuser;            // [3:0] status, [4] woke_valid

  // Mirror of the lock state, updated at every request transfer.
  logic                            lock_held = 1'b0;
  logic [rlwq_pkg::ID_BITS-1:0]    lock_owner = '0;
  logic [rlwq_pkg::COUNT_BITS-1:0] lock_depth = '0;
  logic [rlwq_pkg::ID_BITS-1:0]    waiter_line[$];
  bit                              waiter_flag[rlwq_pkg::ID_SPACE];

  lock_outcome_t pending_outcomes[$];
  int unsigned   error_count = 0;

  // Sender burst state and receiver stall pattern.
  int unsigned   burst_left = 0;
  logic [15:0]   stall_pattern = 16'hFFFF;
  logic [5:0]    stall_tick = '0;

  recursive_lock_with_wait_queue_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the outcome of one accepted request and advance the mirror.
  task automatic predict_lock_outcome(input rlwq_pkg::func_t op,
                                      input logic [7:0] requester);
    logic [rlwq_pkg::ID_BITS-1:0] id;
    lock_outcome_t                res;
    id = requester[rlwq_pkg::ID_BITS-1:0];
    res.woke_valid = 1'b0;
    res.woke_id    = '0;
    if (op == rlwq_pkg::FUNC_ACQUIRE) begin
      if (!lock_held) begin
        lock_held  = 1'b1;
        lock_owner = id;
        lock_depth = rlwq_pkg::COUNT_ONE;
        res.status = rlwq_pkg::ST_GRANTED;
      end else if (lock_owner == id) begin
        // hold the count at its ceiling and flag it
        if (lock_depth == rlwq_pkg::COUNT_MAX) begin
          res.status = rlwq_pkg::ST_OVERFLOW;
        end else begin
          lock_depth = lock_depth + 1'b1;
          res.status = rlwq_pkg::ST_NESTED;
        end
      end else if (waiter_flag[id]) begin
        // duplicate check wins over the full check
        res.status = rlwq_pkg::ST_DUP_WAITER;
      end else if (waiter_line.size() >= rlwq_pkg::QUEUE_DEPTH) begin
        res.status = rlwq_pkg::ST_QUEUE_FULL;
      end else begin
        waiter_line.push_back(id);
        waiter_flag[id] = 1'b1;
        res.status = rlwq_pkg::ST_QUEUED;
      end
    end else begin
      if (!lock_held || lock_owner != id) begin
        res.status = rlwq_pkg::ST_NOT_HOLDER;
      end else if (lock_depth > rlwq_pkg::COUNT_ONE) begin
        lock_depth = lock_depth - 1'b1;
        res.status = rlwq_pkg::ST_UNNESTED;
      end else if (waiter_line.size() > 0) begin
        // hand the lock straight to the oldest waiter
        lock_owner = waiter_line.pop_front();
        waiter_flag[lock_owner] = 1'b0;
        lock_depth = rlwq_pkg::COUNT_ONE;
        res.status = rlwq_pkg::ST_HANDED;
        res.woke_valid = 1'b1;
        res.woke_id = lock_owner;
      end else begin
        lock_held  = 1'b0;
        lock_owner = '0;
        lock_depth = '0;
        res.status = rlwq_pkg::ST_FREED;
      end
    end
    res.hold_count = rlwq_pkg::HOLD_WIDTH'(lock_depth);
    pending_outcomes.push_back(res);
  endtask

  // Drive one request, idling between bursts, and wait for its transfer.
  task automatic send_request(input rlwq_pkg::func_t op, input logic [7:0] requester);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      // drop valid for the gap; it is raised again below for this request
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= requester;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_lock_outcome(op, requester);
    burst_left--;
  endtask

  // Receiver: stall from a 16-bit pattern indexed by a free-running tick, reloaded when the tick wraps.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == 6'd63) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    m_tready <= stall_pattern[stall_tick[3:0]];
  end

  // Compare each result transfer with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    lock_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d tdata %h", m_tuser[3:0], m_tdata);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tuser[3:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser[3:0]);
          error_count++;
        end
        if (m_tuser[4] !== want.woke_valid) begin
          $error("woke_valid: expected %0d, got %0d", want.woke_valid, m_tuser[4]);
          error_count++;
        end
        if (m_tdata[7:0] !== want.woke_id) begin
          $error("woke_id: expected %0d, got %0d", want.woke_id, m_tdata[7:0]);
          error_count++;
        end
        if (m_tdata[15:8] !== want.hold_count) begin
          $error("hold_count: expected %0d, got %0d", want.hold_count, m_tdata[15:8]);
          error_count++;
        end
      end
    end
  end

  // Grant, nesting, unnesting, freeing and releases by a non-holder.
  task automatic test_grant_and_nesting();
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'h00);
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'h00);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'hFF);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'h00);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'h00);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'h00);  // release of a free lock
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'hFF);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'hFF);
  endtask

  // Queueing, duplicate waiters and handoff down the waiter line.
  task automatic test_queue_and_handoff();
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'h5A);
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'hA5);
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'hA5);
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'h00);
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'hFF);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'h5A);
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'hA5);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'hA5);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'hA5);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'h00);
    send_request(rlwq_pkg::FUNC_RELEASE, 8'hFF);
  endtask

  // Fill the waiter line, overflow it, then drain it by handoff.
  task automatic test_queue_full();
    int i;
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'd1);
    for (i = 2; i < rlwq_pkg::QUEUE_DEPTH + 2; i++) begin
      send_request(rlwq_pkg::FUNC_ACQUIRE, 8'(i));
    end
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'd200);
    send_request(rlwq_pkg::FUNC_ACQUIRE, 8'd2);  // already waiting on a full line
    for (i = 1; i < rlwq_pkg::QUEUE_DEPTH + 2; i++) begin
      send_request(rlwq_pkg::FUNC_RELEASE, 8'(i));
    end
  endtask

  // Push the holder's nesting count to its ceiling, overflow it, then unwind a few levels.
  task automatic test_nest_overflow();
    logic [7:0] holder;
    if (!lock_held) begin
      send_request(rlwq_pkg::FUNC_ACQUIRE, 8'd200);
    end
    holder = 8'(lock_owner);
    send_request(rlwq_pkg::FUNC_ACQUIRE, holder + 8'd1);
    while (lock_depth != rlwq_pkg::COUNT_MAX) begin
      send_request(rlwq_pkg::FUNC_ACQUIRE, holder);
    end
    send_request(rlwq_pkg::FUNC_ACQUIRE, holder);
    repeat (4) send_request(rlwq_pkg::FUNC_RELEASE, holder);
  endtask

  // Mostly well-formed traffic from a small id pool, plus random noise.
  task automatic test_random_traffic();
    logic [7:0]  id_pool[24];
    int unsigned round, n, roll, acquire_pct;
    for (round = 0; round < 2; round++) begin
      foreach (id_pool[k]) id_pool[k] = 8'($urandom_range(0, 255));
      acquire_pct = $urandom_range(15, 50);
      for (n = 0; n < 45; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < acquire_pct) begin
          send_request(rlwq_pkg::FUNC_ACQUIRE, id_pool[$urandom_range(0, 23)]);
        end else if (roll < acquire_pct + 35 && lock_held) begin
          send_request(rlwq_pkg::FUNC_RELEASE, lock_owner);
        end else if (roll < acquire_pct + 45 && lock_held) begin
          send_request(rlwq_pkg::FUNC_ACQUIRE, lock_owner);
        end else begin
          send_request(rlwq_pkg::func_t'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_grant_and_nesting();
    test_queue_and_handoff();
    test_queue_full();
    test_random_traffic();
    test_nest_overflow();
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    // allow for any stray result behind the last one
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS recursive_lock_with_wait_queue_core");
    end else begin
      $display("FAIL recursive_lock_with_wait_queue_core");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL recursive_lock_with_wait_queue_core");
    $finish;
  end

endmodule
